// File: sv/softmax_dense_layer_trainer_core_macros.svh
// assertion macros for the softmax layer trainer
`ifndef SOFTMAX_DENSE_LAYER_TRAINER_CORE_MACROS_SVH
`define SOFTMAX_DENSE_LAYER_TRAINER_CORE_MACROS_SVH

// same-cycle implication
`define SDLT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDLT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sdlt_pkg.sv
// types, constants and helpers for the softmax layer trainer
package sdlt_pkg;

   localparam int NUM_INPUTS_DEF  = 16;
   localparam int NUM_OUTPUTS_DEF = 16;

   localparam int VAL_W  = 20;
   localparam int PROB_W = 17;
   localparam int GRAD_W = 21;
   localparam int Z_W    = 48;
   localparam int E_W    = 25;
   localparam int SUM_W  = 34;
   localparam int REM_W  = 50;
   localparam int PROD_W = 60;
   localparam int MA_W   = 38;
   localparam int MB_W   = 22;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [16:0] POLY_SEED = 17'd87;

   typedef enum logic [2:0] {
      CMD_WR_WEIGHT = 3'd0,
      CMD_WR_ACT    = 3'd1,
      CMD_FORWARD   = 3'd2,
      CMD_WR_TARGET = 3'd3,
      CMD_UPDATE    = 3'd4
   } cmd_type;

   typedef enum logic [21:0] {
      ST_IDLE   = 22'h000001,
      ST_T_RD   = 22'h000002,
      ST_T_WR   = 22'h000004,
      ST_F_RD   = 22'h000008,
      ST_F_MUL  = 22'h000010,
      ST_F_ACC  = 22'h000020,
      ST_E_RD   = 22'h000040,
      ST_E_X    = 22'h000080,
      ST_E_M    = 22'h000100,
      ST_E_Y    = 22'h000200,
      ST_E_P    = 22'h000400,
      ST_E_T    = 22'h000800,
      ST_E_E    = 22'h001000,
      ST_D_RD   = 22'h002000,
      ST_D_INIT = 22'h004000,
      ST_D_IT   = 22'h008000,
      ST_D_OUT  = 22'h010000,
      ST_U_RD   = 22'h020000,
      ST_U_M1   = 22'h040000,
      ST_U_M2   = 22'h080000,
      ST_U_M3   = 22'h100000,
      ST_U_WB   = 22'h200000
   } state_type;

   function automatic logic [16:0] poly_coef(input logic [2:0] j);
      logic [16:0] c;
      unique case (j)
         3'd0:    c = 17'd630;
         3'd1:    c = 17'd3638;
         3'd2:    c = 17'd15743;
         3'd3:    c = 17'd45426;
         default: c = 17'd65536;
      endcase
      return c;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat20(input logic signed [31:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 32'sd524287) r = 20'sd524287;
      else if (v < -32'sd524288) r = -20'sd524288;
      else r = v[VAL_W-1:0];
      return r;
   endfunction

endpackage

// File: sv/softmax_dense_layer_trainer_core.sv
// softmax output layer with momentum training, top level
// usage:
//  req channel carries one command word per handshake; req_tuser is the command,
//  req_tdata holds the source index, destination index and a signed Q3.16 value
//  weight and activation writes finish in idle, a target write goes through ST_T_RD and ST_T_WR
//  a forward pass does one multiply-accumulate per weight on the shared multiplier,
//  then per output neuron an exponential (six multiplies) and a probability
//  (17-step restoring divider)
//  an update pass does three multiplies per weight on the shared multiplier
//  req_tready is high only while no command is in progress
//  rsp channel returns one probability word per output neuron, tlast on the final one;
//  a stalled receiver holds the sequencer before the next division result
//  reset clears all control, the delta, output and gradient stores through valid bits
//  and restores learning rate and momentum; weights and activations must be written
//  csr port: learning rate at byte 0, momentum at byte 4
`include "softmax_dense_layer_trainer_core_macros.svh"
module softmax_dense_layer_trainer_core
   import sdlt_pkg::*;
#(
   parameter int NUM_INPUTS  = NUM_INPUTS_DEF,
   parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // src_index, dst_index, value, zero pad
   input  logic [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_index, probability, zero pad
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = $clog2(NUM_INPUTS);
   localparam int OW = $clog2(NUM_OUTPUTS);
   localparam int NW = NUM_INPUTS * NUM_OUTPUTS;
   localparam int AW = $clog2(NW);

   state_type state_ff, state_in;
   logic [IW-1:0] m_ff, m_in;
   logic [OW-1:0] n_ff, n_in;
   logic [2:0] j_ff, j_in;
   logic [4:0] bit_ff, bit_in;
   logic [15:0] eta_ff, alpha_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] dvalid_ff;
   logic [NUM_OUTPUTS-1:0] gvalid_ff, ovalid_ff;

   logic signed [Z_W-1:0] acc_ff, acc_in, zmax_ff, zmax_in;
   logic [31:0] x_ff, x_in;
   logic [16:0] k_ff, k_in, t_ff, t_in;
   logic [15:0] f_ff, f_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [REM_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [PROB_W-1:0] q_ff, q_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, tot_ff, tot_in;
   logic [3:0] rsp_idx_ff, rsp_idx_in;
   logic [PROB_W-1:0] rsp_prob_ff, rsp_prob_in;
   logic rsp_last_ff, rsp_last_in;
   logic [3:0] tgt_dst_ff, tgt_dst_in;
   logic signed [VAL_W-1:0] tgt_val_ff, tgt_val_in;
   logic tgt_ok_ff, tgt_ok_in;

   logic signed [VAL_W-1:0] w_mem [NW];
   logic signed [VAL_W-1:0] d_mem [NW];
   logic signed [VAL_W-1:0] a_mem [NUM_INPUTS];
   logic signed [GRAD_W-1:0] g_mem [NUM_OUTPUTS];
   logic [PROB_W-1:0] o_mem [NUM_OUTPUTS];
   logic signed [Z_W-1:0] z_mem [NUM_OUTPUTS];
   logic [E_W-1:0] e_mem [NUM_OUTPUTS];

   logic signed [VAL_W-1:0] w_rd_ff, d_rd_ff, a_rd_ff;
   logic signed [GRAD_W-1:0] g_rd_ff;
   logic [PROB_W-1:0] o_rd_ff;
   logic signed [Z_W-1:0] z_rd_ff;
   logic [E_W-1:0] e_rd_ff;
   logic dv_rd_ff, gv_rd_ff, ov_rd_ff;

   logic [AW-1:0] w_addr, req_w_addr, w_waddr;
   logic [OW-1:0] o_raddr;
   logic w_we, a_we, d_we, g_we, o_we;
   logic signed [VAL_W-1:0] w_wdata, d_new, w_new;
   logic signed [GRAD_W-1:0] g_new;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic req_acc, src_ok, dst_ok, m_last, n_last;
   logic [3:0] req_src, req_dst;
   logic signed [VAL_W-1:0] req_val;
   logic signed [Z_W-1:0] acc_sum, z_gap;
   logic signed [PROD_W-1:0] tot_sum;
   logic signed [31:0] d_round;
   logic [E_W-1:0] e_val;
   logic signed [VAL_W-1:0] old_delta;
   logic signed [GRAD_W-1:0] grad;

   assign req_src = req_tdata[3:0];
   assign req_dst = req_tdata[7:4];
   assign req_val = req_tdata[27:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign src_ok = 32'(req_src) < NUM_INPUTS;
   assign dst_ok = 32'(req_dst) < NUM_OUTPUTS;
   assign m_last = (m_ff == IW'(NUM_INPUTS - 1));
   assign n_last = (n_ff == OW'(NUM_OUTPUTS - 1));
   assign w_addr = AW'(32'(m_ff) * NUM_OUTPUTS + 32'(n_ff));
   assign req_w_addr = AW'(32'(req_src) * NUM_OUTPUTS + 32'(req_dst));
   assign o_raddr = OW'(tgt_dst_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_prob_ff, rsp_idx_ff};
   assign rsp_tlast = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {16'h0000, alpha_ff} : {16'h0000, eta_ff};

   assign old_delta = dv_rd_ff ? d_rd_ff : '0;
   assign grad = gv_rd_ff ? g_rd_ff : '0;
   assign acc_sum = acc_ff + prod_ff[Z_W-1:0];
   assign z_gap = zmax_ff - z_rd_ff;
   assign e_val = (k_ff > 17'd24) ? '0 : (E_W'({t_ff, 8'h00}) >> k_ff[4:0]);
   assign tot_sum = tot_ff + (prod_ff <<< 16) + (PROD_W'(1) <<< 31);
   assign d_round = 32'(tot_sum >>> 32);
   assign d_new = sat20(d_round);
   assign w_new = sat20(32'(w_rd_ff) + 32'(d_new));
   assign g_new = GRAD_W'(tgt_val_ff) - $signed({4'b0000, ov_rd_ff ? o_rd_ff : '0});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_F_MUL: begin
            mul_a = MA_W'(a_rd_ff);
            mul_b = MB_W'(w_rd_ff);
         end
         ST_E_M: begin
            mul_a = $signed({6'b000000, x_ff});
            mul_b = $signed({5'b00000, LOG2E_Q16});
         end
         ST_E_P: begin
            mul_a = $signed({22'h0, f_ff});
            mul_b = $signed({5'b00000, t_ff});
         end
         ST_U_M1: begin
            mul_a = MA_W'(a_rd_ff);
            mul_b = $signed({6'b000000, eta_ff});
         end
         ST_U_M2: begin
            mul_a = prod_ff[MA_W-1:0];
            mul_b = MB_W'(grad);
         end
         ST_U_M3: begin
            mul_a = MA_W'(old_delta);
            mul_b = $signed({6'b000000, alpha_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      n_in = n_ff;
      j_in = j_ff;
      bit_in = bit_ff;
      acc_in = acc_ff;
      zmax_in = zmax_ff;
      x_in = x_ff;
      k_in = k_ff;
      f_in = f_ff;
      t_in = t_ff;
      sum_in = sum_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      q_in = q_ff;
      prod_in = prod_ff;
      tot_in = tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in = rsp_idx_ff;
      rsp_prob_in = rsp_prob_ff;
      rsp_last_in = rsp_last_ff;
      tgt_dst_in = tgt_dst_ff;
      tgt_val_in = tgt_val_ff;
      tgt_ok_in = tgt_ok_ff;
      w_we = 1'b0;
      w_waddr = req_w_addr;
      w_wdata = req_val;
      a_we = 1'b0;
      d_we = 1'b0;
      g_we = 1'b0;
      o_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               m_in = '0;
               n_in = '0;
               acc_in = '0;
               sum_in = '0;
               unique case (req_tuser)
                  CMD_WR_WEIGHT: w_we = src_ok && dst_ok;
                  CMD_WR_ACT: a_we = src_ok;
                  CMD_FORWARD: state_in = ST_F_RD;
                  CMD_WR_TARGET: begin
                     tgt_dst_in = req_dst;
                     tgt_val_in = req_val;
                     tgt_ok_in = dst_ok;
                     state_in = ST_T_RD;
                  end
                  CMD_UPDATE: state_in = ST_U_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_T_RD: state_in = ST_T_WR;
         ST_T_WR: begin
            g_we = tgt_ok_ff;
            state_in = ST_IDLE;
         end
         ST_F_RD: state_in = ST_F_MUL;
         ST_F_MUL: begin
            prod_in = mul_a * mul_b;
            state_in = ST_F_ACC;
         end
         ST_F_ACC: begin
            state_in = ST_F_RD;
            if (m_last) begin
               acc_in = '0;
               m_in = '0;
               if (n_ff == '0 || acc_sum > zmax_ff) zmax_in = acc_sum;
               if (n_last) begin
                  n_in = '0;
                  state_in = ST_E_RD;
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end else begin
               acc_in = acc_sum;
               m_in = m_ff + 1'b1;
            end
         end
         ST_E_RD: state_in = ST_E_X;
         ST_E_X: begin
            x_in = (z_gap[Z_W-1:16] > 32'h8000_0000) ? 32'h8000_0000 : z_gap[Z_W-1:16];
            state_in = ST_E_M;
         end
         ST_E_M: begin
            prod_in = mul_a * mul_b;
            state_in = ST_E_Y;
         end
         ST_E_Y: begin
            k_in = prod_ff[48:32];
            f_in = prod_ff[31:16];
            t_in = POLY_SEED;
            j_in = '0;
            state_in = ST_E_P;
         end
         ST_E_P: begin
            prod_in = mul_a * mul_b;
            state_in = ST_E_T;
         end
         ST_E_T: begin
            t_in = poly_coef(j_ff) - prod_ff[32:16];
            j_in = j_ff + 3'd1;
            state_in = (j_ff == 3'd4) ? ST_E_E : ST_E_P;
         end
         ST_E_E: begin
            sum_in = sum_ff + SUM_W'(e_val);
            if (n_last) begin
               n_in = '0;
               state_in = ST_D_RD;
            end else begin
               n_in = n_ff + 1'b1;
               state_in = ST_E_RD;
            end
         end
         ST_D_RD: state_in = ST_D_INIT;
         ST_D_INIT: begin
            rem_in = REM_W'({e_rd_ff, 16'h0000}) + REM_W'(sum_ff >> 1);
            div_in = REM_W'({sum_ff, 16'h0000});
            q_in = '0;
            bit_in = 5'd16;
            state_in = ST_D_IT;
         end
         ST_D_IT: begin
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
               q_in = {q_ff[PROB_W-2:0], 1'b1};
            end else begin
               q_in = {q_ff[PROB_W-2:0], 1'b0};
            end
            div_in = div_ff >> 1;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) state_in = ST_D_OUT;
         end
         ST_D_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in = 4'(n_ff);
               rsp_prob_in = q_ff;
               rsp_last_in = n_last;
               o_we = 1'b1;
               if (n_last) begin
                  n_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  n_in = n_ff + 1'b1;
                  state_in = ST_D_RD;
               end
            end
         end
         ST_U_RD: state_in = ST_U_M1;
         ST_U_M1: begin
            prod_in = mul_a * mul_b;
            state_in = ST_U_M2;
         end
         ST_U_M2: begin
            prod_in = mul_a * mul_b;
            state_in = ST_U_M3;
         end
         ST_U_M3: begin
            tot_in = prod_ff;
            prod_in = mul_a * mul_b;
            state_in = ST_U_WB;
         end
         ST_U_WB: begin
            d_we = 1'b1;
            w_we = 1'b1;
            w_waddr = w_addr;
            w_wdata = w_new;
            state_in = ST_U_RD;
            if (m_last) begin
               m_in = '0;
               if (n_last) begin
                  n_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  n_in = n_ff + 1'b1;
               end
            end else begin
               m_in = m_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         m_ff <= '0;
         n_ff <= '0;
         j_ff <= '0;
         bit_ff <= '0;
         rsp_valid_ff <= 1'b0;
         eta_ff <= 16'd9830;
         alpha_ff <= 16'd32768;
         dvalid_ff <= '0;
         gvalid_ff <= '0;
         ovalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         m_ff <= m_in;
         n_ff <= n_in;
         j_ff <= j_in;
         bit_ff <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2]) alpha_ff <= csr_pwdata[15:0];
            else eta_ff <= csr_pwdata[15:0];
         end
         if (d_we) dvalid_ff[w_addr] <= 1'b1;
         if (g_we) gvalid_ff[o_raddr] <= 1'b1;
         if (o_we) ovalid_ff[n_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      zmax_ff <= zmax_in;
      x_ff <= x_in;
      k_ff <= k_in;
      f_ff <= f_in;
      t_ff <= t_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff <= q_in;
      prod_ff <= prod_in;
      tot_ff <= tot_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_last_ff <= rsp_last_in;
      tgt_dst_ff <= tgt_dst_in;
      tgt_val_ff <= tgt_val_in;
      tgt_ok_ff <= tgt_ok_in;
   end

   // storage
   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_waddr] <= w_wdata;
      if (d_we) d_mem[w_addr] <= d_new;
      if (a_we) a_mem[IW'(req_src)] <= req_val;
      if (g_we) g_mem[o_raddr] <= g_new;
      if (o_we) o_mem[n_ff] <= q_ff;
      if (state_ff == ST_F_ACC && m_last) z_mem[n_ff] <= acc_sum;
      if (state_ff == ST_E_E) e_mem[n_ff] <= e_val;
      w_rd_ff <= w_mem[w_addr];
      d_rd_ff <= d_mem[w_addr];
      dv_rd_ff <= dvalid_ff[w_addr];
      a_rd_ff <= a_mem[m_ff];
      g_rd_ff <= g_mem[n_ff];
      gv_rd_ff <= gvalid_ff[n_ff];
      o_rd_ff <= o_mem[o_raddr];
      ov_rd_ff <= ovalid_ff[o_raddr];
      z_rd_ff <= z_mem[n_ff];
      e_rd_ff <= e_mem[n_ff];
   end

   `SDLT_ASSERT_NOW(a_div_bound, clock, reset, state_ff == ST_D_IT, rem_ff < (div_ff << 1), "divider remainder out of range")
   `SDLT_ASSERT_NOW(a_poly_steps, clock, reset, state_ff == ST_E_T || state_ff == ST_E_P, j_ff <= 3'd4, "polynomial step count overrun")
   `SDLT_ASSERT_NOW(a_prob_max, clock, reset, rsp_valid_ff, rsp_prob_ff <= 17'd65536, "probability above one")
   `SDLT_ASSERT_NEXT(a_div_done, clock, reset, state_ff == ST_D_IT && bit_ff == 5'd0, state_ff == ST_D_OUT, "divider did not finish")

endmodule
